// File: hw/rtl/dvc_pkg.sv
`default_nettype none

package dvc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // a value travelling down the chain
    typedef struct packed {
        logic                      valid;
        logic                      consumed;
        logic                      last;
        logic signed [VALUE_W-1:0] value;
    } t_token;

    // what one cell holds
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } t_entry;

endpackage

`default_nettype wire

// File: hw/rtl/dvc_if.sv
`default_nettype none

interface dvc_in_if;
    import dvc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      end_of_set;

    modport source (output valid, output sample_value, output end_of_set, input ready);
    modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface dvc_out_if;
    import dvc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] distinct_value;
    logic [COUNT_W-1:0]        occurrence_count;
    logic                      table_overflowed;
    logic                      last_entry;

    modport source (output valid, output distinct_value, output occurrence_count,
                    output table_overflowed, output last_entry, input ready);
    modport sink   (input valid, input distinct_value, input occurrence_count,
                    input table_overflowed, input last_entry, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dvc_cell.sv
`default_nettype none

module dvc_cell
    import dvc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_token i_tok,
    input  wire t_entry i_next_entry,
    input  wire logic   i_shift,
    output t_token      o_tok,
    output t_entry      o_entry
);

    t_token r_tok;
    t_entry r_entry;
    t_token n_tok;
    t_entry n_entry;
    logic   w_live;
    logic   w_hit;
    logic   w_claim;

    assign w_live  = i_tok.valid && !i_tok.consumed;
    assign w_hit   = w_live && r_entry.valid && (r_entry.value == i_tok.value);
    assign w_claim = w_live && !r_entry.valid;

    always_comb begin
        n_tok          = i_tok;
        n_tok.consumed = i_tok.consumed || w_hit || w_claim;

        n_entry = r_entry;
        if (i_shift) begin
            // drain: take the neighbor's entry, moving toward the output
            n_entry = i_next_entry;
        end else if (w_hit) begin
            if (r_entry.count != COUNT_MAX) begin
                n_entry.count = r_entry.count + COUNT_W'(1);
            end
        end else if (w_claim) begin
            n_entry.valid = 1'b1;
            n_entry.value = i_tok.value;
            n_entry.count = COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid   <= 1'b0;
            r_entry.valid <= 1'b0;
        end else begin
            r_tok.valid   <= n_tok.valid;
            r_entry.valid <= n_entry.valid;
        end
        r_tok.consumed <= n_tok.consumed;
        r_tok.last     <= n_tok.last;
        r_tok.value    <= n_tok.value;
        r_entry.value  <= n_entry.value;
        r_entry.count  <= n_entry.count;
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: hw/rtl/distinct_value_counter.sv
// channel  dir  beat payload                                          handshake
// i_in     in   sample_value[31:0] s, end_of_set                      valid/ready
// o_out    out  distinct_value[31:0] s, occurrence_count[15:0],
//               table_overflowed, last_entry                          valid/ready
//
// values stream in at one beat per cycle while ready is high; each passes one cell per cycle
// after end_of_set the input holds off while the marker walks the chain through
// every cell and the entries drain, then one entry leaves per cycle the sink takes it
// reset (synchronous, active low) empties the chain; sink stalls freeze the drain
`default_nettype none

module distinct_value_counter
    import dvc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dvc_in_if.sink    i_in,
    dvc_out_if.source o_out
);

    t_token              w_tok   [0:TABLE_DEPTH];
    t_entry              w_ent   [0:TABLE_DEPTH-1];
    t_entry              w_nb    [0:TABLE_DEPTH-1];
    logic [TABLE_DEPTH-1:0] w_used;

    logic r_busy;
    logic r_drain;
    logic r_overflow;
    logic n_busy;
    logic n_drain;
    logic n_overflow;

    logic w_in_acc;
    logic w_out_acc;
    logic w_shift;
    logic w_last_beat;
    t_token w_exit;

    assign i_in.ready = !r_busy;
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].valid    = w_in_acc;
        w_tok[0].consumed = 1'b0;
        w_tok[0].last     = i_in.end_of_set;
        w_tok[0].value    = i_in.sample_value;
    end

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
            if (k == TABLE_DEPTH - 1) begin : g_tail
                assign w_nb[k] = '0;
            end else begin : g_mid
                assign w_nb[k] = w_ent[k+1];
            end
            assign w_used[k] = w_ent[k].valid;

            dvc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_tok        (w_tok[k]),
                .i_next_entry (w_nb[k]),
                .i_shift      (w_shift),
                .o_tok        (w_tok[k+1]),
                .o_entry      (w_ent[k])
            );
        end
    endgenerate

    assign w_exit = w_tok[TABLE_DEPTH];

    assign o_out.valid            = r_drain && w_ent[0].valid;
    assign o_out.distinct_value   = w_ent[0].value;
    assign o_out.occurrence_count = w_ent[0].count;
    assign o_out.table_overflowed = r_overflow;
    assign o_out.last_entry       = !w_ent[1].valid;

    assign w_out_acc   = o_out.valid && o_out.ready;
    assign w_shift     = w_out_acc;
    assign w_last_beat = w_out_acc && o_out.last_entry;

    always_comb begin
        n_busy     = r_busy;
        n_drain    = r_drain;
        n_overflow = r_overflow;
        if (w_in_acc && i_in.end_of_set) begin
            n_busy = 1'b1;
        end
        // a value that found neither a match nor a free cell is dropped
        if (w_exit.valid && !w_exit.consumed) begin
            n_overflow = 1'b1;
        end
        if (w_exit.valid && w_exit.last) begin
            n_drain = 1'b1;
        end
        if (w_last_beat) begin
            n_busy     = 1'b0;
            n_drain    = 1'b0;
            n_overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_drain    <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_drain    <= n_drain;
            r_overflow <= n_overflow;
        end
    end

    // occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_used & (w_used + TABLE_DEPTH'(1))) == '0)
        else $error("occupied cells are not a prefix");

    // no new values while a run is being emitted
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input open during emission");

    // the end marker closes the input until the run is out
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.end_of_set) |=> !i_in.ready)
        else $error("input still open after end of set");

    // the final entry of a run leaves the chain empty and the flag clear
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_beat |=> (w_used == '0) && !r_overflow && i_in.ready)
        else $error("chain not cleared after run");

endmodule

`default_nettype wire

// File: tb/distinct_value_counter_tb.sv
`timescale 1ns / 1ps

module distinct_value_counter_tb;
    import dvc_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_set;
        int                        send_idle;
        int                        recv_stall;
        bit                        drain_first;
    } t_sample_beat;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
        logic                      overflowed;
        logic                      last;
    } t_histo_entry;

    logic i_clk;
    logic i_rst_n;

    dvc_in_if  in_bus ();
    dvc_out_if out_bus ();

    distinct_value_counter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_sample_beat pending_beats[$];
    t_histo_entry expected_entries[$];

    // own copy of the histogram table
    logic signed [VALUE_W-1:0] tally_value[TABLE_DEPTH];
    logic [COUNT_W-1:0]        tally_count[TABLE_DEPTH];
    int                        tally_used = 0;
    bit                        tally_overflow = 1'b0;

    int mismatch_count = 0;
    int recv_stall_pct = 0;

    // idle profile and drain request applied to beats as they are queued
    int cur_send_idle  = 0;
    int cur_recv_stall = 0;
    bit drain_next     = 1'b0;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic tally_sample(input logic signed [VALUE_W-1:0] value, input logic last);
        int           k;
        bit           hit;
        t_histo_entry entry;
        hit = 1'b0;
        for (k = 0; k < tally_used; k++) begin
            if (!hit && tally_value[k] == value) begin
                hit = 1'b1;
                if (tally_count[k] != COUNT_MAX)
                    tally_count[k] = tally_count[k] + 1'b1;
            end
        end
        if (!hit) begin
            if (tally_used < TABLE_DEPTH) begin
                tally_value[tally_used] = value;
                tally_count[tally_used] = COUNT_W'(1);
                tally_used++;
            end else begin
                tally_overflow = 1'b1;
            end
        end
        if (last) begin
            for (k = 0; k < tally_used; k++) begin
                entry.value      = tally_value[k];
                entry.count      = tally_count[k];
                entry.overflowed = tally_overflow;
                entry.last       = (k == tally_used - 1);
                expected_entries.push_back(entry);
            end
            tally_used     = 0;
            tally_overflow = 1'b0;
        end
    endtask

    function automatic void queue_beat(input logic signed [VALUE_W-1:0] value,
                                       input logic last);
        t_sample_beat b;
        b.value       = value;
        b.end_of_set  = last;
        b.send_idle   = cur_send_idle;
        b.recv_stall  = cur_recv_stall;
        b.drain_first = drain_next;
        drain_next    = 1'b0;
        pending_beats.push_back(b);
    endfunction

    // walks n_distinct - 1 consecutive values once, then draws from all n_distinct at random;
    // the closing beat is the highest one, dropped when the table overflows
    function automatic int queue_wide_set(input int n_distinct, input int n_extra);
        logic signed [VALUE_W-1:0] base;
        int                        k;
        base = $urandom;
        for (k = 0; k < n_distinct - 1; k++)
            queue_beat(base + k, 1'b0);
        for (k = 0; k < n_extra; k++)
            queue_beat(base + $urandom_range(n_distinct - 1), 1'b0);
        queue_beat(base + n_distinct - 1, 1'b1);
        return n_distinct + n_extra;
    endfunction

    function automatic int queue_random_set();
        logic signed [VALUE_W-1:0] pool[6];
        int                        kind;
        int                        len;
        int                        k;
        kind = $urandom_range(9);
        if (kind == 9)
            return queue_wide_set($urandom_range(60, 70), $urandom_range(0, 12));
        for (k = 0; k < 6; k++)
            pool[k] = $urandom;
        len = (kind < 7) ? $urandom_range(1, 12) : $urandom_range(1, 20);
        for (k = 0; k < len; k++) begin
            if (kind < 7)
                queue_beat(pool[$urandom_range(5)], k == len - 1);
            else
                queue_beat($urandom, k == len - 1);
        end
        return len;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                tally_sample(in_bus.sample_value, in_bus.end_of_set);
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_beats.size() > 0
                        && !(pending_beats[0].drain_first && expected_entries.size() > 0)
                        && $urandom_range(99) >= pending_beats[0].send_idle) begin
                    in_bus.valid        <= 1'b1;
                    in_bus.sample_value <= pending_beats[0].value;
                    in_bus.end_of_set   <= pending_beats[0].end_of_set;
                    recv_stall_pct = pending_beats[0].recv_stall;
                    void'(pending_beats.pop_front());
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_histo_entry want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_entries.size() == 0) begin
                    report_mismatch($sformatf("unexpected entry value %0d count %0d",
                                              out_bus.distinct_value,
                                              out_bus.occurrence_count));
                end else begin
                    want = expected_entries.pop_front();
                    if (out_bus.distinct_value !== want.value)
                        report_mismatch($sformatf("distinct_value %0d, want %0d",
                                                  out_bus.distinct_value, want.value));
                    if (out_bus.occurrence_count !== want.count)
                        report_mismatch($sformatf("occurrence_count %0d, want %0d (value %0d)",
                                                  out_bus.occurrence_count, want.count,
                                                  want.value));
                    if (out_bus.table_overflowed !== want.overflowed)
                        report_mismatch($sformatf("table_overflowed %b, want %b",
                                                  out_bus.table_overflowed, want.overflowed));
                    if (out_bus.last_entry !== want.last)
                        report_mismatch($sformatf("last_entry %b, want %b",
                                                  out_bus.last_entry, want.last));
                end
            end
            out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int ph;
        int phase_beats;

        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.sample_value = '0;
        in_bus.end_of_set   = 1'b0;
        out_bus.ready       = 1'b0;

        // directed sets: extremes, single-beat set, repeats, last beat a repeat
        queue_beat(32'sh8000_0000, 1'b1);
        queue_beat(32'sh7fff_ffff, 1'b0);
        queue_beat(32'sh0000_0000, 1'b0);
        queue_beat(-32'sd1, 1'b0);
        queue_beat(32'sh7fff_ffff, 1'b0);
        queue_beat(32'sh0000_0000, 1'b0);
        queue_beat(32'sh7fff_ffff, 1'b0);
        queue_beat(32'sh5555_5555, 1'b0);
        queue_beat(32'shaaaa_aaaa, 1'b1);
        queue_beat(32'sd7, 1'b0);
        queue_beat(32'sd7, 1'b0);
        queue_beat(32'sd7, 1'b1);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin cur_send_idle = 0;  cur_recv_stall = 0;  end
                1: begin cur_send_idle = 47; cur_recv_stall = 0;  end
                2: begin cur_send_idle = 0;  cur_recv_stall = 47; end
                default: begin cur_send_idle = 23; cur_recv_stall = 23; end
            endcase
            drain_next  = 1'b1;
            phase_beats = 0;
            // phase 0 overflows the table with new values, phase 1 fills it exactly
            if (ph == 1)
                phase_beats += queue_wide_set(TABLE_DEPTH, 6);
            if (ph == 0)
                phase_beats += queue_wide_set(TABLE_DEPTH + 2, 10);
            while (phase_beats < 72)
                phase_beats += queue_random_set();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || in_bus.valid)
            @(posedge i_clk);
        while (expected_entries.size() != 0)
            @(posedge i_clk);
        repeat (3 * TABLE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
